// File: rtl/fmf_pkg.sv
// ----------------------------------------------------------------------------
// fmf_pkg
// Shared types, constants and codes of the FIX message framer.
// ----------------------------------------------------------------------------
package fmf_pkg;

	localparam int LEN_BITS    = 20;
	localparam int CNT_W       = LEN_BITS + 1;
	localparam int MUL_W       = CNT_W + 4;
	localparam int BEGIN_LEN   = 10;
	localparam int MPOS_W      = 4;
	localparam int TRAILER_LEN = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [7:0] SOH      = 8'h01;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	localparam logic [7:0] BEGIN_STR [BEGIN_LEN] = '{
		8'h38, 8'h3D, 8'h46, 8'h49, 8'h58, 8'h2E, 8'h34, 8'h2E, 8'h30, 8'h01
	};

	localparam logic [LEN_BITS-1:0] MAX_BODY_RST = LEN_BITS'(4096);
	localparam logic [LEN_BITS-1:0] MAX_HDR_RST  = LEN_BITS'(65535);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HDR  = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_LEN  = 2'd1,
		ERR_HDR  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SEEK,
		PH_LEN,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic [7:0]           data;
		logic [BEGIN_LEN-1:0] begin_eq;
		logic                 is_soh;
		logic                 is_eight;
		logic                 is_nine;
		logic                 is_eq;
		logic                 is_digit;
		logic                 is_space;
		logic                 is_sign;
		logic                 is_minus;
		logic [3:0]           digit;
	} cls_t;

	typedef struct packed {
		logic [7:0] data;
		logic       in_frame;
		logic       first;
		logic       last;
		err_t       err;
	} res_t;

endpackage

// File: rtl/fmf_front.sv
// ----------------------------------------------------------------------------
// fmf_front
// Accepts raw bytes, classifies them and queues them for the framer.
// ----------------------------------------------------------------------------
module fmf_front import fmf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	output logic       full,
	output logic       item_valid,
	output cls_t       item,
	input  logic       item_take
);

	cls_t              cls;
	cls_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr_en;
	logic              rd_en;

	always_comb begin
		cls          = '0;
		cls.data     = data_byte;
		for (int i = 0; i < BEGIN_LEN; i++) begin
			cls.begin_eq[i] = (data_byte == BEGIN_STR[i]);
		end
		cls.is_soh   = (data_byte == SOH);
		cls.is_eight = (data_byte == CH_EIGHT);
		cls.is_nine  = (data_byte == CH_NINE);
		cls.is_eq    = (data_byte == CH_EQ);
		cls.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
		cls.is_space = (data_byte == CH_SPACE) ||
			((data_byte >= CH_TAB) && (data_byte <= CH_CR));
		cls.is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
		cls.is_minus = (data_byte == CH_MINUS);
		cls.digit    = data_byte[3:0];
	end

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = q_mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/fmf_back.sv
// ----------------------------------------------------------------------------
// fmf_back
// Framer state machine: one classified item a cycle while the result queue has room, results to a queue.
// ----------------------------------------------------------------------------
module fmf_back import fmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  cls_t                 item,
	output logic                 item_take,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_BITS-1:0]  cfg_data,
	output logic                 res_valid,
	output res_t                 res,
	input  logic                 res_take
);

	logic [LEN_BITS-1:0] max_body_q;
	logic [LEN_BITS-1:0] max_hdr_q;

	phase_t             phase_q, phase_d;
	logic [MPOS_W-1:0]  mpos_q, mpos_d;
	logic [1:0]         prev_q, prev_d;
	logic [CNT_W-1:0]   acc_q, acc_d;
	logic               dseen_q, dseen_d;
	logic               minus_q, minus_d;
	logic               dend_q, dend_d;
	logic [CNT_W-1:0]   bc_q, bc_d;

	logic [MPOS_W-1:0]  mpos_eff;
	logic               hit;
	logic [CNT_W-1:0]   bc_inc;
	logic               hdr_over;
	logic [MUL_W-1:0]   acc_mul;
	logic [CNT_W-1:0]   acc_sat;
	logic               len_bad;
	logic [CNT_W-1:0]   bc_dec;

	res_t               r;
	res_t               rq_mem_q [QDEPTH];
	logic [QPTR_W-1:0]  rq_wr_q;
	logic [QPTR_W-1:0]  rq_rd_q;
	logic [QCNT_W-1:0]  rq_cnt_q;
	logic               rq_full;
	logic               rq_rd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAX_BODY_RST;
			max_hdr_q  <= MAX_HDR_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_BODY) begin
				max_body_q <= cfg_data;
			end else if (cfg_index == REG_MAX_HDR) begin
				max_hdr_q <= cfg_data;
			end
		end
	end

	assign rq_full   = (rq_cnt_q == QCNT_W'(QDEPTH));
	assign item_take = item_valid && !rq_full;

	assign mpos_eff = (mpos_q >= MPOS_W'(BEGIN_LEN)) ? '0 : mpos_q;
	assign hit      = item.begin_eq[mpos_eff];
	assign bc_inc   = (bc_q == CNT_MAX) ? bc_q : bc_q + 1'b1;
	assign hdr_over = (bc_inc > {1'b0, max_hdr_q});
	assign acc_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + MUL_W'(item.digit);
	assign acc_sat  = (acc_mul > {4'b0000, CNT_MAX}) ? CNT_MAX : acc_mul[CNT_W-1:0];
	assign len_bad  = !dseen_q || (minus_q && (acc_q != '0)) ||
		(acc_q > {1'b0, max_body_q});
	assign bc_dec   = (bc_q != '0) ? bc_q - 1'b1 : '0;

	// next state
	always_comb begin
		phase_d = phase_q;
		mpos_d  = mpos_q;
		prev_d  = prev_q;
		acc_d   = acc_q;
		dseen_d = dseen_q;
		minus_d = minus_q;
		dend_d  = dend_q;
		bc_d    = bc_q;
		case (phase_q)
			PH_HUNT: begin
				if (hit) begin
					if (mpos_eff == MPOS_W'(BEGIN_LEN - 1)) begin
						phase_d = PH_SEEK;
						mpos_d  = '0;
						bc_d    = CNT_W'(BEGIN_LEN);
						prev_d  = 2'd1;
					end else begin
						mpos_d = mpos_eff + 1'b1;
					end
				end else if (item.is_eight) begin
					mpos_d = MPOS_W'(1);
				end else begin
					mpos_d = '0;
				end
			end
			PH_SEEK: begin
				bc_d = bc_inc;
				if (hdr_over) begin
					phase_d = PH_HUNT;
				end else if (item.is_soh) begin
					prev_d = 2'd1;
				end else if (prev_q == 2'd1 && item.is_nine) begin
					prev_d = 2'd2;
				end else if (prev_q == 2'd2 && item.is_eq) begin
					phase_d = PH_LEN;
					prev_d  = '0;
					acc_d   = '0;
					dseen_d = 1'b0;
					minus_d = 1'b0;
					dend_d  = 1'b0;
				end else begin
					prev_d = '0;
				end
			end
			PH_LEN: begin
				if (item.is_soh) begin
					if (len_bad) begin
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_BODY;
						bc_d    = acc_q + CNT_W'(TRAILER_LEN);
						prev_d  = '0;
					end
				end else begin
					bc_d = bc_inc;
					if (hdr_over) begin
						phase_d = PH_HUNT;
					end else if (dend_q) begin
						bc_d = bc_inc;
					end else if (item.is_digit) begin
						dseen_d = 1'b1;
						acc_d   = acc_sat;
					end else if (!dseen_q && prev_q == '0 && item.is_space) begin
						bc_d = bc_inc;
					end else if (!dseen_q && prev_q == '0 && item.is_sign) begin
						prev_d  = 2'd1;
						minus_d = item.is_minus;
					end else begin
						dend_d = 1'b1;
					end
				end
			end
			PH_BODY: begin
				bc_d = bc_dec;
				if (bc_dec == '0) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		// leaving a frame clears the parser
		if (phase_d == PH_HUNT && phase_q != PH_HUNT) begin
			mpos_d  = '0;
			prev_d  = '0;
			acc_d   = '0;
			dseen_d = 1'b0;
			minus_d = 1'b0;
			dend_d  = 1'b0;
			bc_d    = '0;
		end
	end

	// outputs
	always_comb begin
		r          = '0;
		r.data     = item.data;
		r.err      = ERR_NONE;
		case (phase_q)
			PH_HUNT: begin
				if (hit) begin
					r.in_frame = 1'b1;
					r.first    = (mpos_eff == '0);
				end else if (item.is_eight) begin
					r.in_frame = 1'b1;
					r.first    = 1'b1;
				end
			end
			PH_SEEK: begin
				r.in_frame = 1'b1;
				if (hdr_over) begin
					r.err = ERR_HDR;
				end
			end
			PH_LEN: begin
				r.in_frame = 1'b1;
				if (item.is_soh) begin
					if (len_bad) begin
						r.err = ERR_LEN;
					end
				end else if (hdr_over) begin
					r.err = ERR_HDR;
				end
			end
			PH_BODY: begin
				r.in_frame = 1'b1;
				r.last     = (bc_dec == '0);
			end
			default: begin
				r.in_frame = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			mpos_q  <= '0;
			prev_q  <= '0;
			acc_q   <= '0;
			dseen_q <= 1'b0;
			minus_q <= 1'b0;
			dend_q  <= 1'b0;
			bc_q    <= '0;
		end else if (item_take) begin
			phase_q <= phase_d;
			mpos_q  <= mpos_d;
			prev_q  <= prev_d;
			acc_q   <= acc_d;
			dseen_q <= dseen_d;
			minus_q <= minus_d;
			dend_q  <= dend_d;
			bc_q    <= bc_d;
		end
	end

	// result queue
	assign res_valid = (rq_cnt_q != '0);
	assign res       = rq_mem_q[rq_rd_q];
	assign rq_rd     = res_take && res_valid;

	always_ff @(posedge clk) begin
		if (item_take) begin
			rq_mem_q[rq_wr_q] <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (item_take) begin
				rq_wr_q <= rq_wr_q + 1'b1;
			end
			if (rq_rd) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
			if (item_take && !rq_rd) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (rq_rd && !item_take) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/fix_message_framer.sv
// ----------------------------------------------------------------------------
// fix_message_framer
// Byte-stream framer for FIX 4.0 messages with per-byte frame flags.
// ----------------------------------------------------------------------------
// Usage:
// - input: one raw byte per item on data_byte, taken when push is high and
//   full is low; full rises once the 4-entry input queue is occupied
// - results: one item per input byte, shown while empty is low and taken
//   when pop is high; out_byte echoes the byte, in_frame/frame_first/
//   frame_last mark frame membership, error_code flags an aborted frame
// - configuration: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   index 0 is max_body_len, index 1 is max_header_bytes; cfg_ready is
//   always high; users write only while the block is idle, it is not enforced
// - path: a pushed byte is registered in the input queue, then the framer
//   step moves it into the result queue, which drives the result ports
// - throughput: one byte per cycle while the result queue has room
// - reset: both queues empty, framer hunting for the begin string,
//   max_body_len 4096, max_header_bytes 65535
// - stall: the 4-entry result queue fills while pop is low, then the framer
//   holds and the input queue fills, then full rises
// ----------------------------------------------------------------------------
module fix_message_framer import fmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           data_byte,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           out_byte,
	output logic                 in_frame,
	output logic                 frame_first,
	output logic                 frame_last,
	output logic [1:0]           error_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_BITS-1:0]  cfg_data
);

	logic item_valid;
	cls_t item;
	logic item_take;
	logic res_valid;
	res_t res;

	assign cfg_ready = 1'b1;

	fmf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	fmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (pop)
	);

	assign empty       = !res_valid;
	assign out_byte    = res.data;
	assign in_frame    = res.in_frame;
	assign frame_first = res.first;
	assign frame_last  = res.last;
	assign error_code  = res.err;

`ifndef SYNTHESIS
	a_first_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_first |-> in_frame)
		else $error("frame start outside a frame");

	a_err_no_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (error_code != ERR_NONE) |-> in_frame && !frame_last)
		else $error("error on a non-frame or final byte");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (error_code == ERR_NONE || error_code == ERR_LEN ||
			error_code == ERR_HDR))
		else $error("undefined error code");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> !empty)
		else $error("framed item lost");
`endif

endmodule
